>>> sv/ipbb_pkg.sv
package ipbb_pkg;

   // Field widths
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned INC_W   = 32;
   localparam int unsigned ERR_W   = SPEED_W + 1;   // target - actual
   localparam int unsigned D1_W    = ERR_W + 1;     // e - last
   localparam int unsigned D2_W    = ERR_W + 2;     // e - 2*last + prev
   localparam int unsigned CORR_W  = 9;             // bang-bang correction, signed
   localparam int unsigned FRAC_W  = 8;             // Q8.8 gains

   // CSR port
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_PROP_GAIN  = 2'd0,
      CSR_INTEG_GAIN = 2'd1,
      CSR_DERIV_GAIN = 2'd2
   } csr_index_type;

   // Gain reset values (Q8.8)
   localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 16'd1280;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 16'd102;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET = 16'd0;

   // Bang-bang bands and corrections
   localparam logic signed [ERR_W-1:0]  BAND_LOW   = -17'sd70;
   localparam logic signed [ERR_W-1:0]  BAND_MID   = -17'sd50;
   localparam logic signed [ERR_W-1:0]  BAND_HIGH  = -17'sd30;
   localparam logic signed [ERR_W-1:0]  BAND_BOOST = 17'sd50;
   localparam logic signed [CORR_W-1:0] CORR_LOW   = -9'sd80;
   localparam logic signed [CORR_W-1:0] CORR_MID   = -9'sd50;
   localparam logic signed [CORR_W-1:0] CORR_HIGH  = -9'sd20;
   localparam logic signed [CORR_W-1:0] CORR_REARM = 9'sd170;
   localparam logic signed [CORR_W-1:0] CORR_BOOST = 9'sd120;

   typedef struct packed {
      logic signed [SPEED_W-1:0] actual_speed;
      logic signed [SPEED_W-1:0] set_speed;
   } req_type;

   typedef struct packed {
      logic signed [INC_W-1:0] increment;
      logic                    bang_active;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] deriv_gain;
   } gains_type;

endpackage

>>> sv/ipbb_csr.sv
module ipbb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ipbb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ipbb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ipbb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output ipbb_pkg::gains_type              gains
);

   ipbb_pkg::gains_type    gains_ff;
   ipbb_pkg::csr_index_type index;
   logic                   wr_en;

   assign index      = ipbb_pkg::csr_index_type'(csr_paddr[ipbb_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign gains      = gains_ff;

   // Gain registers; writes to unused indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop_gain  <= ipbb_pkg::PROP_GAIN_RESET;
         gains_ff.integ_gain <= ipbb_pkg::INTEG_GAIN_RESET;
         gains_ff.deriv_gain <= ipbb_pkg::DERIV_GAIN_RESET;
      end else if (wr_en) begin
         unique case (index)
            ipbb_pkg::CSR_PROP_GAIN:  gains_ff.prop_gain  <= csr_pwdata[ipbb_pkg::GAIN_W-1:0];
            ipbb_pkg::CSR_INTEG_GAIN: gains_ff.integ_gain <= csr_pwdata[ipbb_pkg::GAIN_W-1:0];
            ipbb_pkg::CSR_DERIV_GAIN: gains_ff.deriv_gain <= csr_pwdata[ipbb_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = '0;
      unique case (index)
         ipbb_pkg::CSR_PROP_GAIN:
            csr_prdata = ipbb_pkg::CSR_DATA_W'(gains_ff.prop_gain);
         ipbb_pkg::CSR_INTEG_GAIN:
            csr_prdata = ipbb_pkg::CSR_DATA_W'(gains_ff.integ_gain);
         ipbb_pkg::CSR_DERIV_GAIN:
            csr_prdata = ipbb_pkg::CSR_DATA_W'(gains_ff.deriv_gain);
         default: csr_prdata = '0;
      endcase
   end

endmodule

>>> sv/incremental_pid_bang_boost_unit.sv
// Incremental PID speed controller with bang-bang boost. Each request beat
// carries a measured and a target speed; each one yields exactly one response
// beat with the drive increment and the bang-bang flag, in order. The unit
// takes a new beat every cycle while req_ready is high. The errors, differences
// and band correction are registered in stage 1 at accept. The three Q8.8 gain
// products are registered next in stage 2, and the sum/round/correction result
// then loads the output register. Each stage holds its beat independently, so
// a stalled response only blocks input once all three stages are full. Gains
// are set through the CSR port (prop 0x0, integ 0x4, deriv 0x8) and should be
// written while idle.
module incremental_pid_bang_boost_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ipbb_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ipbb_pkg::rsp_type                rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ipbb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ipbb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ipbb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int unsigned ERR_W  = ipbb_pkg::ERR_W;
   localparam int unsigned D1_W   = ipbb_pkg::D1_W;
   localparam int unsigned D2_W   = ipbb_pkg::D2_W;
   localparam int unsigned GAIN_W = ipbb_pkg::GAIN_W;
   localparam int unsigned CORR_W = ipbb_pkg::CORR_W;
   localparam int unsigned FRAC_W = ipbb_pkg::FRAC_W;
   localparam int unsigned INC_W  = ipbb_pkg::INC_W;
   localparam int unsigned PI_W   = GAIN_W + 1 + ERR_W;
   localparam int unsigned PP_W   = GAIN_W + 1 + D1_W;
   localparam int unsigned PD_W   = GAIN_W + 1 + D2_W;
   localparam int unsigned ACC_W  = PD_W + 2;
   localparam int unsigned Q_W    = ACC_W - FRAC_W;

   ipbb_pkg::gains_type gains;

   ipbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   // Stage handshake: each stage moves when the next one is empty or moving
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_adv, s2_adv, out_adv;
   logic accept;

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || out_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Error history and flag
   logic signed [ERR_W-1:0] last_err_ff, prev_err_ff;
   logic                    bang_flag_ff;

   logic signed [ERR_W-1:0]  err;
   logic signed [D1_W-1:0]   d1;
   logic signed [D2_W-1:0]   d2;
   logic signed [CORR_W-1:0] corr;
   logic                     bang_in;

   always_comb begin
      err = ERR_W'(req_data.set_speed) - ERR_W'(req_data.actual_speed);
      d1  = D1_W'(err) - D1_W'(last_err_ff);
      d2  = D2_W'(err) - (D2_W'(last_err_ff) <<< 1) + D2_W'(prev_err_ff);
      corr    = '0;
      bang_in = bang_flag_ff;
      if (err < ipbb_pkg::BAND_LOW) begin
         corr    = ipbb_pkg::CORR_LOW;
         bang_in = 1'b1;
      end else if (err < ipbb_pkg::BAND_MID) begin
         corr    = ipbb_pkg::CORR_MID;
         bang_in = 1'b1;
      end else if (err < ipbb_pkg::BAND_HIGH) begin
         corr    = ipbb_pkg::CORR_HIGH;
         bang_in = 1'b1;
      end else if (err > ipbb_pkg::BAND_BOOST) begin
         // boost clears the flag; a larger kick when it re-arms from bang
         corr    = bang_flag_ff ? ipbb_pkg::CORR_REARM : ipbb_pkg::CORR_BOOST;
         bang_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff  <= '0;
         prev_err_ff  <= '0;
         bang_flag_ff <= 1'b0;
      end else if (accept) begin
         prev_err_ff  <= last_err_ff;
         last_err_ff  <= err;
         bang_flag_ff <= bang_in;
      end
   end

   // Stage 1: errors, differences, correction
   logic signed [ERR_W-1:0]  s1_err_ff;
   logic signed [D1_W-1:0]   s1_d1_ff;
   logic signed [D2_W-1:0]   s1_d2_ff;
   logic signed [CORR_W-1:0] s1_corr_ff;
   logic                     s1_bang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_err_ff  <= err;
         s1_d1_ff   <= d1;
         s1_d2_ff   <= d2;
         s1_corr_ff <= corr;
         s1_bang_ff <= bang_in;
      end
   end

   // Stage 2: gain products
   logic signed [PP_W-1:0]   s2_pp_ff;
   logic signed [PI_W-1:0]   s2_pi_ff;
   logic signed [PD_W-1:0]   s2_pd_ff;
   logic signed [CORR_W-1:0] s2_corr_ff;
   logic                     s2_bang_ff;
   logic signed [PP_W-1:0]   pp_in;
   logic signed [PI_W-1:0]   pi_in;
   logic signed [PD_W-1:0]   pd_in;

   always_comb begin
      pp_in = PP_W'($signed({1'b0, gains.prop_gain}))  * PP_W'(s1_d1_ff);
      pi_in = PI_W'($signed({1'b0, gains.integ_gain})) * PI_W'(s1_err_ff);
      pd_in = PD_W'($signed({1'b0, gains.deriv_gain})) * PD_W'(s1_d2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         s2_pp_ff   <= pp_in;
         s2_pi_ff   <= pi_in;
         s2_pd_ff   <= pd_in;
         s2_corr_ff <= s1_corr_ff;
         s2_bang_ff <= s1_bang_ff;
      end
   end

   // Stage 3: sum, divide by 256 toward zero, add correction.
   // |sum|/256 stays below 2^27, so neither clamp to 32 bits can trigger.
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_biased;
   logic signed [Q_W-1:0]   quot;
   logic signed [INC_W-1:0] inc_in;

   always_comb begin
      acc = ACC_W'(s2_pp_ff) + ACC_W'(s2_pi_ff) + ACC_W'(s2_pd_ff);
      // negative values get 255 added so the shift truncates toward zero
      acc_biased = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
      quot       = acc_biased[ACC_W-1:FRAC_W];
      inc_in     = INC_W'(quot) + INC_W'(s2_corr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s2_valid_ff) begin
         rsp_data.increment   <= inc_in;
         rsp_data.bang_active <= s2_bang_ff;
      end
   end

endmodule

>>> tb/sv/tb_incremental_pid_bang_boost_unit.sv
`timescale 1ns / 100ps

module tb_incremental_pid_bang_boost_unit;

   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     DRAIN_CYCLES   = 6;
   localparam int     HOLD_CYCLES    = 300;
   localparam int     MAX_GAP        = 30;
   localparam int     ITEMS_PER_PHASE = 162;
   localparam int     HOLD_ITEMS     = 48;
   localparam longint GAIN_ONE       = 256;
   localparam longint INC_HI         = 64'sd2147483647;
   localparam longint INC_LO         = -64'sd2147483648;

   // Bang-bang thresholds and corrections on the error
   localparam longint BAND_LOW_ERR  = -70;
   localparam longint BAND_MID_ERR  = -50;
   localparam longint BAND_HIGH_ERR = -30;
   localparam longint BOOST_ERR     = 50;
   localparam longint DROP_LOW      = 80;
   localparam longint DROP_MID      = 50;
   localparam longint DROP_HIGH     = 20;
   localparam longint REARM_ADD     = 170;
   localparam longint BOOST_ADD     = 120;

   // Address past the last gain register, writes there are dropped
   localparam logic [ipbb_pkg::CSR_ADDR_W-1:0] UNUSED_CSR_ADDR = 4'hC;

   // Idle/stall percentages per random phase
   localparam int IDLE_PCT  [4] = '{0, 71, 0, 31};
   localparam int STALL_PCT [4] = '{0, 0, 71, 31};

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   ipbb_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_ready;
   ipbb_pkg::rsp_type               rsp_data;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [ipbb_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [ipbb_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [ipbb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   incremental_pid_bang_boost_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Controller model state
   ipbb_pkg::gains_type               gain_model;
   logic signed [ipbb_pkg::ERR_W-1:0] err_last;
   logic signed [ipbb_pkg::ERR_W-1:0] err_prev;
   bit                                boost_flag;
   ipbb_pkg::rsp_type                 pending_incs [$];

   int  mismatch_count;
   int  quiet_cycles;
   int  req_idle_pct;
   int  rsp_stall_pct;
   bit  hold_armed;
   bit  hold_done;

   // Directed rows: gain preset, speeds, and a hand-worked result where obvious
   typedef struct {
      int gain_set;
      int actual;
      int target;
      bit typed;
      int exp_inc;
      bit exp_flag;
   } speed_row_type;

   ipbb_pkg::gains_type gain_presets [3] = '{
      '{16'd1280, 16'd102, 16'd0},
      '{16'd0,    16'd0,   16'd0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF}
   };

   speed_row_type directed_rows [23] = '{
      // reset gains: zero error, small step, high band, boost after band
      '{0, 0, 0, 1, 0, 0},
      '{0, 0, 10, 1, 53, 0},
      '{0, 40, 0, 1, -285, 1},
      '{0, 0, 100, 0, 0, 0},
      '{0, 0, 100, 0, 0, 0},
      '{0, -32768, 32767, 0, 0, 0},
      '{0, 32767, -32768, 0, 0, 0},
      // zero gains: the increment is the band correction alone
      '{1, 0, 0, 1, 0, 1},
      '{1, 0, 51, 1, 170, 0},
      '{1, 0, 51, 1, 120, 0},
      '{1, 0, 50, 1, 0, 0},
      '{1, 30, 0, 1, 0, 0},
      '{1, 31, 0, 1, -20, 1},
      '{1, 50, 0, 1, -20, 1},
      '{1, 51, 0, 1, -50, 1},
      '{1, 70, 0, 1, -50, 1},
      '{1, 71, 0, 1, -80, 1},
      '{1, 0, 51, 1, 170, 0},
      // full-scale gains with full-scale error swings
      '{2, -32768, 32767, 0, 0, 0},
      '{2, 32767, -32768, 0, 0, 0},
      '{2, 32767, -32768, 0, 0, 0},
      '{2, -32768, -32768, 0, 0, 0},
      '{2, 32767, 32767, 0, 0, 0}
   };

   function automatic longint sat_inc(longint v);
      if (v > INC_HI) return INC_HI;
      if (v < INC_LO) return INC_LO;
      return v;
   endfunction

   // One controller step: PID increment, band correction, history shift
   function automatic ipbb_pkg::rsp_type pid_step(ipbb_pkg::req_type item);
      longint            err;
      longint            d1;
      longint            d2;
      longint            acc;
      longint            inc;
      ipbb_pkg::rsp_type r;
      err = longint'(item.set_speed) - longint'(item.actual_speed);
      d1  = err - longint'(err_last);
      d2  = err - 2 * longint'(err_last) + longint'(err_prev);
      acc = longint'(gain_model.prop_gain) * d1
          + longint'(gain_model.integ_gain) * err
          + longint'(gain_model.deriv_gain) * d2;
      inc = sat_inc(acc / GAIN_ONE);
      err_prev = err_last;
      err_last = err[ipbb_pkg::ERR_W-1:0];
      if (err < BAND_LOW_ERR) begin
         boost_flag = 1'b1;
         inc -= DROP_LOW;
      end else if (err < BAND_MID_ERR) begin
         boost_flag = 1'b1;
         inc -= DROP_MID;
      end else if (err < BAND_HIGH_ERR) begin
         boost_flag = 1'b1;
         inc -= DROP_HIGH;
      end
      if (err > BOOST_ERR) begin
         if (boost_flag) begin
            boost_flag = 1'b0;
            inc += REARM_ADD;
         end else begin
            inc += BOOST_ADD;
         end
      end
      inc = sat_inc(inc);
      r.increment   = inc[ipbb_pkg::INC_W-1:0];
      r.bang_active = boost_flag;
      return r;
   endfunction

   function automatic logic [ipbb_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return ipbb_pkg::GAIN_W'($urandom_range(2047));
         default: return ipbb_pkg::GAIN_W'($urandom());
      endcase
   endfunction

   // Mostly near-equal speeds so the bands and rearm path are hit often
   function automatic ipbb_pkg::req_type random_speeds();
      ipbb_pkg::req_type r;
      int                a;
      int                s;
      a = int'($urandom_range(65535)) - 32768;
      case ($urandom_range(9))
         0: s = $urandom_range(1) ? 32767 : -32768;
         1, 2, 3: s = int'($urandom_range(65535)) - 32768;
         default: s = a + int'($urandom_range(240)) - 120;
      endcase
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      if ($urandom_range(19) == 0) a = $urandom_range(1) ? 32767 : -32768;
      r.actual_speed = a[ipbb_pkg::SPEED_W-1:0];
      r.set_speed    = s[ipbb_pkg::SPEED_W-1:0];
      return r;
   endfunction

   // Called at a rising edge; returns at the edge after the write edge
   task automatic csr_write(input logic [ipbb_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [ipbb_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr[ipbb_pkg::CSR_ADDR_W-1:2])
         ipbb_pkg::CSR_PROP_GAIN:
            gain_model.prop_gain  = data[ipbb_pkg::GAIN_W-1:0];
         ipbb_pkg::CSR_INTEG_GAIN:
            gain_model.integ_gain = data[ipbb_pkg::GAIN_W-1:0];
         ipbb_pkg::CSR_DERIV_GAIN:
            gain_model.deriv_gain = data[ipbb_pkg::GAIN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Upper data bits carry noise; the unused address is hit each time
   task automatic load_gains(input ipbb_pkg::gains_type g);
      csr_write({ipbb_pkg::CSR_PROP_GAIN, 2'b00}, {16'($urandom()), g.prop_gain});
      csr_write({ipbb_pkg::CSR_INTEG_GAIN, 2'b00}, {16'($urandom()), g.integ_gain});
      csr_write({ipbb_pkg::CSR_DERIV_GAIN, 2'b00}, {16'($urandom()), g.deriv_gain});
      csr_write(UNUSED_CSR_ADDR, $urandom());
   endtask

   // Called at a rising edge; returns at the edge that takes the beat
   task automatic send_speed(input ipbb_pkg::req_type item, input bit typed,
                             input ipbb_pkg::rsp_type typed_rsp);
      ipbb_pkg::rsp_type predicted;
      int                gap;
      gap = 0;
      while (gap < MAX_GAP && int'($urandom_range(99)) < req_idle_pct) gap++;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(negedge clock); while (!req_ready);
      predicted = pid_step(item);
      pending_incs.push_back(typed ? typed_rsp : predicted);
      @(posedge clock);
   endtask

   // Stop offering and wait until every outstanding beat is back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_incs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Response side: random stalls plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
            hold_done = 1'b1;
         end
         rsp_ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
      end
   end

   // Response check and watchdog, sampled mid-cycle
   always @(negedge clock) begin
      ipbb_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_incs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response beat: increment %0d bang %0b",
                           rsp_data.increment, rsp_data.bang_active);
            end else begin
               want = pending_incs.pop_front();
               if (rsp_data.increment !== want.increment ||
                   rsp_data.bang_active !== want.bang_active) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: increment exp %0d got %0d, bang exp %0b got %0b",
                              want.increment, rsp_data.increment,
                              want.bang_active, rsp_data.bang_active);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("tb_incremental_pid_bang_boost_unit: FAIL");
            $finish;
         end
      end
   end

   // Main sequence
   initial begin
      ipbb_pkg::rsp_type typed_rsp;
      ipbb_pkg::req_type item;
      int                cur_set;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      req_idle_pct   = 0;
      rsp_stall_pct  = 0;
      hold_armed     = 1'b0;
      gain_model     = gain_presets[0];
      err_last       = '0;
      err_prev       = '0;
      boost_flag     = 1'b0;
      cur_set        = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; gains change only between presets, with the unit idle
      foreach (directed_rows[i]) begin
         if (directed_rows[i].gain_set != cur_set) begin
            settle();
            cur_set = directed_rows[i].gain_set;
            load_gains(gain_presets[cur_set]);
         end
         item.actual_speed     = directed_rows[i].actual[ipbb_pkg::SPEED_W-1:0];
         item.set_speed        = directed_rows[i].target[ipbb_pkg::SPEED_W-1:0];
         typed_rsp.increment   = directed_rows[i].exp_inc;
         typed_rsp.bang_active = directed_rows[i].exp_flag;
         send_speed(item, directed_rows[i].typed, typed_rsp);
      end

      // Long response hold-off while input keeps coming, so the pipe backs up
      settle();
      load_gains('{pick_gain(), pick_gain(), pick_gain()});
      hold_armed = 1'b1;
      repeat (HOLD_ITEMS) send_speed(random_speeds(), 1'b0, '0);
      wait (hold_done);
      hold_armed = 1'b0;

      // Random phases over the idle/stall mixes, new gains each phase
      for (int ph = 0; ph < 8; ph++) begin
         settle();
         load_gains('{pick_gain(), pick_gain(), pick_gain()});
         req_idle_pct  = IDLE_PCT[ph % 4];
         rsp_stall_pct = STALL_PCT[ph % 4];
         repeat (ITEMS_PER_PHASE) send_speed(random_speeds(), 1'b0, '0);
      end

      settle();
      if (mismatch_count == 0)
         $display("tb_incremental_pid_bang_boost_unit: PASS");
      else
         $display("tb_incremental_pid_bang_boost_unit: FAIL");
      $finish;
   end

endmodule
